// ----- rtl/fis_pkg.sv -----
// ----------------------------------------------------------------------------
// fis_pkg: shared types and constants of the frame interval statistics block
// Transaction payload structs, command codes and the saturating helper.
// ----------------------------------------------------------------------------
package fis_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int STAMP_W           = 48;
    localparam int STAT_W            = 32;
    localparam int EXP_W             = 20;
    localparam int FPS_SCALE         = 1000000;
    localparam logic [EXP_W-1:0] EXPECTED_RESET = 20'd16670;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef struct packed {
        logic               command;
        logic [STAMP_W-1:0] timestamp_us;
    } fis_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] fps;
        logic [STAT_W-1:0] last_interval_us;
        logic [STAT_W-1:0] min_interval_us;
        logic [STAT_W-1:0] max_interval_us;
        logic [STAT_W-1:0] avg_interval_us;
        logic [STAT_W-1:0] drop_count;
        logic [STAT_W-1:0] frame_total;
    } fis_out_t;

    // Clamp a value to the 32-bit statistic range.
    function automatic logic [STAT_W-1:0] sat_u32(input logic [63:0] v);
        logic [STAT_W-1:0] r;
        r = (|v[63:STAT_W]) ? {STAT_W{1'b1}} : v[STAT_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/fis_ring.sv -----
// ----------------------------------------------------------------------------
// fis_ring: timestamp history ring
// Single-port-write, registered-read memory plus the wrapping write index.
// ----------------------------------------------------------------------------
module fis_ring #(
    parameter int DEPTH = fis_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [fis_pkg::STAMP_W-1:0]  wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [fis_pkg::STAMP_W-1:0]  rd_data,
    output logic [$clog2(DEPTH)-1:0]     wr_index
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [fis_pkg::STAMP_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0]            wr_index_reg;
    logic [IDX_W-1:0]            wr_index_next;
    logic [fis_pkg::STAMP_W-1:0] rd_data_reg;

    always_comb begin
        wr_index_next = wr_index_reg;
        if (wr_en) begin
            wr_index_next = (wr_index_reg == IDX_W'(DEPTH - 1)) ? '0
                                                               : wr_index_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_index_reg <= '0;
        end else begin
            wr_index_reg <= wr_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_index_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign wr_index = wr_index_reg;

endmodule

// ----- rtl/fis_divider.sv -----
// ----------------------------------------------------------------------------
// fis_divider: shared serial divider
// Restoring division, one quotient bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module fis_divider #(
    parameter int DIV_W = 39,
    parameter int DEN_W = fis_pkg::STAMP_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/frame_interval_stats.sv -----
// A record transaction is taken in ST_IDLE, and s_ready stays high after it.
// A report walks a window of S stamps, S being the window size (up to
// HISTORY_DEPTH, one ring read per cycle), and then uses the shared serial
// divider, DIV_W bits wide (39 bits at the default depth), for rate and mean.
// Only one report is in flight; s_ready is low until its result is registered.
// Reset (aresetn, synchronous, active low) clears all control state at once.
// ----------------------------------------------------------------------------
// frame_interval_stats: sliding-window frame rate meter
// Records frame timestamps into a history ring, counts late frames, and on a
// report walks the window to produce rate and interval statistics.
// ----------------------------------------------------------------------------
module frame_interval_stats #(
    parameter int HISTORY_DEPTH = fis_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  fis_pkg::fis_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output fis_pkg::fis_out_t         m_data,
    input  logic                      cfg_wr_en,
    input  logic [fis_pkg::EXP_W-1:0] cfg_wr_data
);

    localparam int STAMP_W = fis_pkg::STAMP_W;
    localparam int STAT_W  = fis_pkg::STAT_W;
    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = STAT_W + CNT_W;
    localparam longint NUM_MAX = longint'(HISTORY_DEPTH - 1) * fis_pkg::FPS_SCALE;
    localparam int NUM_W   = $clog2(NUM_MAX + 1);
    localparam int DIV_W   = (SUM_W > NUM_W) ? SUM_W : NUM_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_FPS  = 3'd2;
    localparam logic [2:0] ST_MEAN = 3'd3;
    localparam logic [2:0] ST_AVG  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [fis_pkg::EXP_W-1:0] expected_reg, expected_next;
    logic [STAT_W-1:0]        frames_reg, frames_next;
    logic [STAT_W-1:0]        drops_reg, drops_next;
    logic [STAMP_W-1:0]       prev_reg, prev_next;
    logic                     have_prev_reg, have_prev_next;
    logic [STAMP_W-1:0]       now_reg, now_next;
    logic [CNT_W-1:0]         samp_reg, samp_next;
    logic [IDX_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [STAMP_W-1:0]       cur_reg, cur_next;
    logic [STAT_W-1:0]        last_reg, last_next;
    logic [STAT_W-1:0]        min_reg, min_next;
    logic [STAT_W-1:0]        max_reg, max_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [STAT_W-1:0]        fps_reg, fps_next;
    logic [STAT_W-1:0]        avg_reg, avg_next;
    logic                     m_valid_reg, m_valid_next;
    fis_pkg::fis_out_t        m_data_reg, m_data_next;

    logic                     accept;
    logic                     do_record;
    logic                     do_report;
    logic [IDX_W-1:0]         wr_index;
    logic [STAMP_W-1:0]       rd_data;
    logic [STAMP_W-1:0]       gap;
    logic                     late;
    logic [STAMP_W-1:0]       step_diff;
    logic [STAT_W-1:0]        step_gap;
    logic                     step_ok;
    logic [STAMP_W-1:0]       span;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [STAMP_W-1:0]       div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quotient;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign do_record = accept && (s_data.command == fis_pkg::CMD_RECORD);
    assign do_report = accept && (s_data.command == fis_pkg::CMD_REPORT);

    // A frame is late when twice its gap exceeds three expected intervals.
    // Gaps are taken modulo 2^48, so time running backwards reads as late.
    assign gap  = s_data.timestamp_us - prev_reg;
    assign late = ({gap, 1'b0} > (((STAMP_W + 1)'(expected_reg) << 1) +
                                  (STAMP_W + 1)'(expected_reg)));

    // One interval of the window walk: the newer stamp is held in cur_reg and
    // the older one arrives from the ring.
    assign step_diff = cur_reg - rd_data;
    assign step_gap  = fis_pkg::sat_u32(64'(step_diff));
    assign step_ok   = (cur_reg != '0) && (rd_data != '0);
    assign span      = now_reg - rd_data;

    // No unwritten ring entry is ever used: a report only looks
    // back over min(frames, HISTORY_DEPTH) entries, all of them recorded since
    // reset, so the frame count stands in for clearing the memory.
    fis_ring #(
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (do_record),
        .wr_data  (s_data.timestamp_us),
        .rd_addr  (rd_ptr_reg),
        .rd_data  (rd_data),
        .wr_index (wr_index)
    );

    // One divider serves both the frame rate and the mean interval.
    fis_divider #(
        .DIV_W (DIV_W),
        .DEN_W (STAMP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        frames_next    = frames_reg;
        drops_next     = drops_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        now_next       = now_reg;
        samp_next      = samp_reg;
        rd_ptr_next    = rd_ptr_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        fps_next       = fps_reg;
        avg_next       = avg_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        if (cfg_wr_en) begin
            expected_next = cfg_wr_data;
        end

        // The output register frees up as soon as its transaction is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (do_record) begin
                    frames_next    = frames_reg + 1'b1;
                    prev_next      = s_data.timestamp_us;
                    have_prev_next = 1'b1;
                    if (have_prev_reg && late) begin
                        drops_next = drops_reg + 1'b1;
                    end
                end else if (do_report) begin
                    now_next   = s_data.timestamp_us;
                    samp_next  = (frames_reg < STAT_W'(HISTORY_DEPTH)) ?
                                 CNT_W'(frames_reg) : CNT_W'(HISTORY_DEPTH);
                    // Point at the newest entry; the walk moves backwards.
                    rd_ptr_next = (wr_index == '0) ? IDX_W'(HISTORY_DEPTH - 1)
                                                   : wr_index - 1'b1;
                    j_next      = '0;
                    last_next   = '0;
                    min_next    = '1;
                    max_next    = '0;
                    sum_next    = '0;
                    count_next  = '0;
                    fps_next    = '0;
                    avg_next    = '0;
                    // A window of fewer than two frames has no intervals.
                    if (frames_reg < STAT_W'(2)) begin
                        state_next = ST_MEAN;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                // rd_data holds the entry j_reg - 1 places back from the newest,
                // while the next older entry is being read.
                rd_ptr_next = (rd_ptr_reg == '0) ? IDX_W'(HISTORY_DEPTH - 1)
                                                 : rd_ptr_reg - 1'b1;
                j_next      = j_reg + 1'b1;
                if (j_reg != '0) begin
                    cur_next = rd_data;
                end
                if (j_reg >= CNT_W'(2) && step_ok) begin
                    if (j_reg == CNT_W'(2)) begin
                        last_next = step_gap;
                    end
                    if (step_gap < min_reg) begin
                        min_next = step_gap;
                    end
                    if (step_gap > max_reg) begin
                        max_next = step_gap;
                    end
                    sum_next   = sum_reg + SUM_W'(step_gap);
                    count_next = count_reg + 1'b1;
                end
                if (j_reg == samp_reg) begin
                    // The oldest stamp of the window sets the rate span.
                    if (rd_data != '0 && span != '0) begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(samp_reg - 1'b1) *
                                       DIV_W'(fis_pkg::FPS_SCALE);
                        div_divisor  = span;
                        state_next   = ST_FPS;
                    end else begin
                        state_next = ST_MEAN;
                    end
                end
            end

            ST_FPS: begin
                if (div_done) begin
                    fps_next   = fis_pkg::sat_u32(64'(div_quotient));
                    state_next = ST_MEAN;
                end
            end

            ST_MEAN: begin
                if (count_reg != '0) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(sum_reg);
                    div_divisor  = STAMP_W'(count_reg);
                    state_next   = ST_AVG;
                end else begin
                    // No valid interval: minimum reports zero, not all ones.
                    min_next   = '0;
                    avg_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_AVG: begin
                if (div_done) begin
                    avg_next   = fis_pkg::sat_u32(64'(div_quotient));
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.fps              = fps_reg;
                    m_data_next.last_interval_us = last_reg;
                    m_data_next.min_interval_us  = min_reg;
                    m_data_next.max_interval_us  = max_reg;
                    m_data_next.avg_interval_us  = avg_reg;
                    m_data_next.drop_count       = drops_reg;
                    m_data_next.frame_total      = frames_reg;
                    state_next                   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            expected_reg  <= fis_pkg::EXPECTED_RESET;
            frames_reg    <= '0;
            drops_reg     <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            frames_reg    <= frames_next;
            drops_reg     <= drops_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        samp_reg   <= samp_next;
        rd_ptr_reg <= rd_ptr_next;
        j_reg      <= j_next;
        cur_reg    <= cur_next;
        last_reg   <= last_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        fps_reg    <= fps_next;
        avg_reg    <= avg_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/fis_checker.sv -----
// ----------------------------------------------------------------------------
// fis_checker: port-level checks of the frame interval statistics block
// Watches the transaction ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fis_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input fis_pkg::fis_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input fis_pkg::fis_out_t m_data
);

    // A result waiting for the sink keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A report holds off further input while it is worked out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == fis_pkg::CMD_REPORT |=> !s_ready)
        else $error("input taken during a report");

    // Recording a frame never stalls the input channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == fis_pkg::CMD_RECORD |=> s_ready)
        else $error("record transaction stalled the input");

    // A new result only appears at the end of a report.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without a report in progress");

endmodule

bind frame_interval_stats fis_checker u_fis_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- sim/frame_stats_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_stats_checker: prediction and comparison for frame_interval_stats
// Watches the input, result and configuration ports, keeps its own copy of the
// timestamp history, and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_stats_checker #(
    parameter int DEPTH = fis_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  fis_pkg::fis_in_t          s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  fis_pkg::fis_out_t         m_data,
    input  logic                      cfg_wr_en,
    input  logic [fis_pkg::EXP_W-1:0] cfg_wr_data,
    output int                        error_count,
    output int                        pending_reports
);

    logic [fis_pkg::STAMP_W-1:0] stamp_hist [DEPTH];
    int                          wr_ptr;
    logic [fis_pkg::STAT_W-1:0]  frame_cnt;
    logic [fis_pkg::STAT_W-1:0]  drop_cnt;
    logic [fis_pkg::STAMP_W-1:0] prev_stamp;
    logic                        prev_ok;
    logic [fis_pkg::EXP_W-1:0]   frame_period;
    fis_pkg::fis_out_t           expected_stats_q [$];
    fis_pkg::fis_out_t           want_stats;

    function automatic logic [fis_pkg::STAT_W-1:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[fis_pkg::STAT_W-1:0];
    endfunction

    // Entry k places behind the write pointer, 1 <= k <= DEPTH.
    function automatic logic [fis_pkg::STAMP_W-1:0] hist_back(input int k);
        return stamp_hist[(wr_ptr + DEPTH - k) % DEPTH];
    endfunction

    task automatic record_frame(input logic [fis_pkg::STAMP_W-1:0] now);
        logic [fis_pkg::STAMP_W-1:0] gap;
        stamp_hist[wr_ptr] = now;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        frame_cnt = frame_cnt + 1'b1;
        if (prev_ok) begin
            gap = now - prev_stamp;
            if ((64'(gap) << 1) > 64'(frame_period) * 64'd3)
                drop_cnt = drop_cnt + 1'b1;
        end
        prev_stamp = now;
        prev_ok    = 1'b1;
    endtask

    function automatic fis_pkg::fis_out_t window_stats(
        input logic [fis_pkg::STAMP_W-1:0] now);
        fis_pkg::fis_out_t           r;
        int                          n;
        int                          cnt;
        logic [fis_pkg::STAMP_W-1:0] oldest;
        logic [fis_pkg::STAMP_W-1:0] cur;
        logic [fis_pkg::STAMP_W-1:0] prv;
        logic [fis_pkg::STAMP_W-1:0] diff;
        logic [fis_pkg::STAT_W-1:0]  d;
        logic [fis_pkg::STAT_W-1:0]  lo;
        logic [fis_pkg::STAT_W-1:0]  hi;
        logic [63:0]                 total;
        r = '0;
        n = (frame_cnt < DEPTH) ? int'(frame_cnt) : DEPTH;
        if (n >= 2) begin
            oldest = hist_back(n);
            if (oldest != '0) begin
                diff = now - oldest;
                if (diff != '0)
                    r.fps = clamp32(64'(n - 1) * 64'(fis_pkg::FPS_SCALE) / 64'(diff));
            end
            cur = hist_back(1);
            prv = hist_back(2);
            if (cur != '0 && prv != '0) begin
                diff = cur - prv;
                r.last_interval_us = clamp32(64'(diff));
            end
            cnt   = 0;
            lo    = '1;
            hi    = '0;
            total = '0;
            for (int i = 1; i < n; i++) begin
                cur = hist_back(i);
                prv = hist_back(i + 1);
                if (cur == '0 || prv == '0)
                    continue;
                diff  = cur - prv;
                d     = clamp32(64'(diff));
                lo    = (d < lo) ? d : lo;
                hi    = (d > hi) ? d : hi;
                total = total + 64'(d);
                cnt++;
            end
            if (cnt > 0) begin
                r.min_interval_us = lo;
                r.max_interval_us = hi;
                r.avg_interval_us = fis_pkg::STAT_W'(total / 64'(cnt));
            end
        end
        r.drop_count  = drop_cnt;
        r.frame_total = frame_cnt;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name,
                               input logic [fis_pkg::STAT_W-1:0] got,
                               input logic [fis_pkg::STAT_W-1:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (stamp_hist[j])
                stamp_hist[j] = '0;
            wr_ptr       = 0;
            frame_cnt    = '0;
            drop_cnt     = '0;
            prev_stamp   = '0;
            prev_ok      = 1'b0;
            frame_period = fis_pkg::EXPECTED_RESET;
            expected_stats_q.delete();
        end else begin
            if (cfg_wr_en)
                frame_period = cfg_wr_data;
            if (s_valid && s_ready) begin
                if (s_data.command == fis_pkg::CMD_RECORD)
                    record_frame(s_data.timestamp_us);
                else
                    expected_stats_q.push_back(window_stats(s_data.timestamp_us));
            end
            if (m_valid && m_ready) begin
                if (expected_stats_q.size() == 0) begin
                    note_mismatch("result transaction with no report outstanding");
                end else begin
                    want_stats = expected_stats_q.pop_front();
                    check_field("fps", m_data.fps, want_stats.fps);
                    check_field("last_interval_us", m_data.last_interval_us,
                                want_stats.last_interval_us);
                    check_field("min_interval_us", m_data.min_interval_us,
                                want_stats.min_interval_us);
                    check_field("max_interval_us", m_data.max_interval_us,
                                want_stats.max_interval_us);
                    check_field("avg_interval_us", m_data.avg_interval_us,
                                want_stats.avg_interval_us);
                    check_field("drop_count", m_data.drop_count, want_stats.drop_count);
                    check_field("frame_total", m_data.frame_total, want_stats.frame_total);
                end
            end
        end
        pending_reports = expected_stats_q.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for frame_interval_stats
// Drives frame record and report transactions through a directed opening and
// several randomized phases, each under a different expected frame period, and
// lets frame_stats_checker predict and compare every statistics result.
// ----------------------------------------------------------------------------
module tb;

    // Give records and reports a generous margin before touching the register
    // and before the final verdict.
    localparam int DRAIN_CYCLES = 200;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 215;
    localparam int NUM_PHASES   = 6;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    fis_pkg::fis_in_t          s_data;
    logic                      m_valid;
    logic                      m_ready;
    fis_pkg::fis_out_t         m_data;
    logic                      cfg_wr_en;
    logic [fis_pkg::EXP_W-1:0] cfg_wr_data;

    int               error_count;
    int               pending_reports;
    int               quiet_cycles;
    bit               gaps_on;

    // Stimulus-side bookkeeping: the time base of the frame stream and the
    // stamps still inside the history window, so that some report queries can
    // land exactly on the oldest stamp (the zero-span case).
    logic [fis_pkg::STAMP_W-1:0] stream_time;
    logic [fis_pkg::STAMP_W-1:0] window_stamps [$];

    frame_interval_stats #(
        .HISTORY_DEPTH (fis_pkg::HISTORY_DEPTH_DEF)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    frame_stats_checker #(
        .DEPTH (fis_pkg::HISTORY_DEPTH_DEF)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .error_count     (error_count),
        .pending_reports (pending_reports)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The result side stalls in about a quarter of the cycles, except during
    // the phase that runs with idling switched off.
    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(99) >= 26);
    end

    // Watchdog: any transaction or register write restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [fis_pkg::STAMP_W-1:0] rand_stamp();
        return fis_pkg::STAMP_W'({$urandom, $urandom});
    endfunction

    // Offers one transaction and holds it until the block takes it. Valid is
    // only lowered when an idle cycle is actually inserted, so back-to-back
    // transactions never see valid dropped and raised in the same time step.
    task automatic send_txn(input logic cmd, input logic [fis_pkg::STAMP_W-1:0] stamp);
        fis_pkg::fis_in_t txn;
        txn.command      = cmd;
        txn.timestamp_us = stamp;
        while (gaps_on && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= txn;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (cmd == fis_pkg::CMD_RECORD) begin
            window_stamps.push_back(stamp);
            if (window_stamps.size() > fis_pkg::HISTORY_DEPTH_DEF)
                void'(window_stamps.pop_front());
        end
    endtask

    // Lets every outstanding report come back, waits out any record still in
    // flight, and then writes the expected frame period while the block idles.
    task automatic set_frame_period(input logic [fis_pkg::EXP_W-1:0] period);
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_reports != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= period;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Frame-to-frame gap of a well-formed stream: mostly near the expected
    // period, with a good share right at the drop threshold (2*gap vs 3*period,
    // both sides of it), tiny gaps, late frames and gaps wide enough to
    // saturate a 32-bit interval.
    function automatic logic [fis_pkg::STAMP_W-1:0] next_gap(
        input logic [fis_pkg::EXP_W-1:0] period);
        logic [63:0] p;
        int          roll;
        p    = 64'(period);
        roll = $urandom_range(99);
        if (roll < 50)
            return fis_pkg::STAMP_W'(p - p / 8 + 64'($urandom_range(0, int'(p / 4))));
        else if (roll < 70)
            return fis_pkg::STAMP_W'((3 * p) / 2 + 64'($urandom_range(0, 1)));
        else if (roll < 85)
            return fis_pkg::STAMP_W'($urandom_range(0, 64));
        else if (roll < 95)
            return fis_pkg::STAMP_W'(p * 64'($urandom_range(2, 5)));
        else
            return fis_pkg::STAMP_W'(64'($urandom) << $urandom_range(0, 16));
    endfunction

    // One randomized phase. Most transactions are records of a steadily
    // advancing stream; about one in five is a report, and one in ten is a
    // disturbance: a zero stamp, an arbitrary stamp or time stepping back.
    task automatic run_phase(input int n_items, input logic [fis_pkg::EXP_W-1:0] period);
        int                          roll;
        int                          pick;
        logic [fis_pkg::STAMP_W-1:0] stamp;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
                pick = $urandom_range(9);
                if (pick == 0 && window_stamps.size() > 0)
                    stamp = window_stamps[0];
                else if (pick == 1)
                    stamp = rand_stamp();
                else
                    stamp = stream_time +
                            fis_pkg::STAMP_W'($urandom_range(0, int'(period)));
                send_txn(fis_pkg::CMD_REPORT, stamp);
            end else begin
                if (roll < 30) begin
                    pick = $urandom_range(2);
                    if (pick == 0)
                        stamp = '0;
                    else if (pick == 1)
                        stamp = rand_stamp();
                    else
                        stamp = stream_time - fis_pkg::STAMP_W'($urandom_range(1, 1000));
                end else begin
                    stamp = stream_time + next_gap(period);
                end
                stream_time = stamp;
                send_txn(fis_pkg::CMD_RECORD, stamp);
            end
        end
    endtask

    initial begin
        logic [fis_pkg::EXP_W-1:0] period;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        gaps_on     = 1'b1;
        stream_time = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening, under the reset value of the expected period.
        // An empty window and a single sample must both report zero rate and intervals.
        send_txn(fis_pkg::CMD_REPORT, 48'd5);
        // A zero stamp is held as unwritten; intervals touching it are skipped
        // and a zero oldest stamp gives no frame rate.
        send_txn(fis_pkg::CMD_RECORD, 48'd0);
        send_txn(fis_pkg::CMD_REPORT, 48'd100);
        send_txn(fis_pkg::CMD_RECORD, 48'd16670);
        send_txn(fis_pkg::CMD_REPORT, 48'd20000);
        // Exactly 1.5 periods is not a drop; one microsecond more is.
        send_txn(fis_pkg::CMD_RECORD, 48'd41675);
        send_txn(fis_pkg::CMD_RECORD, 48'd66681);
        send_txn(fis_pkg::CMD_REPORT, 48'd66681);
        // Largest stamp, then a wrap that reads as a small gap, then time
        // going backwards, which shows up as a huge, saturated interval.
        send_txn(fis_pkg::CMD_RECORD, '1);
        send_txn(fis_pkg::CMD_RECORD, 48'd5);
        send_txn(fis_pkg::CMD_RECORD, 48'd3);
        send_txn(fis_pkg::CMD_REPORT, '1);
        // A forward gap wider than 32 bits also saturates.
        send_txn(fis_pkg::CMD_RECORD, 48'd3 + (48'd1 << 33));
        send_txn(fis_pkg::CMD_REPORT, 48'd4 + (48'd1 << 33));
        stream_time = 48'd3 + (48'd1 << 33);

        // Randomized phases: the reset value, both range limits, a zero period
        // (every nonzero gap is a drop), all ones and one random setting. The
        // phase at the upper limit runs without any idling on either side.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: period = fis_pkg::EXPECTED_RESET;
                1: period = 20'd1;
                2: period = 20'd1000000;
                3: period = 20'd0;
                4: period = '1;
                default: period = fis_pkg::EXP_W'($urandom_range(1, 50000));
            endcase
            set_frame_period(period);
            gaps_on = (p != 2);
            run_phase(PHASE_ITEMS, period);
        end

        // Drain: every outstanding report must come back before the verdict.
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_reports != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_reports == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
